/* rtl/uvsq_pkg.sv */
// Shared types, constants and helper functions for the UV sphere quad vertex generator.
// No dependencies; used by every module under rtl/.
package uvsq_pkg;

	// Default values for the top-level parameters
	localparam int MAX_GRID_DEF   = 256;
	localparam int ANGLE_BITS_DEF = 16;

	// Depth of the queue between the front and the back
	localparam int QDEPTH = 16;

	// Configuration register indexes
	localparam logic [1:0] REG_RADIUS       = 2'd0;
	localparam logic [1:0] REG_RING_COUNT   = 2'd1;
	localparam logic [1:0] REG_SECTOR_COUNT = 2'd2;

	// Register reset values
	localparam logic [15:0] RADIUS_RST = 16'd256;
	localparam logic [8:0]  COUNT_RST  = 9'd8;

	// Fourth corner of a quad
	localparam logic [1:0] CORNER_LAST = 2'd3;

	// One ring's results: z coordinate and ring radius
	typedef struct packed {
		logic signed [16:0] zc;
		logic [15:0]        rc;
	} ring_t;

	// Quarter-wave sine table, Q1.15
	function automatic logic [14:0] qsin(input logic [5:0] k);
		logic [14:0] v;
		case (k)
			6'd0:  v = 15'd0;
			6'd1:  v = 15'd1608;
			6'd2:  v = 15'd3212;
			6'd3:  v = 15'd4808;
			6'd4:  v = 15'd6393;
			6'd5:  v = 15'd7962;
			6'd6:  v = 15'd9512;
			6'd7:  v = 15'd11039;
			6'd8:  v = 15'd12540;
			6'd9:  v = 15'd14010;
			6'd10: v = 15'd15447;
			6'd11: v = 15'd16846;
			6'd12: v = 15'd18205;
			6'd13: v = 15'd19520;
			6'd14: v = 15'd20788;
			6'd15: v = 15'd22006;
			6'd16: v = 15'd23170;
			6'd17: v = 15'd24279;
			6'd18: v = 15'd25330;
			6'd19: v = 15'd26320;
			6'd20: v = 15'd27246;
			6'd21: v = 15'd28106;
			6'd22: v = 15'd28899;
			6'd23: v = 15'd29622;
			6'd24: v = 15'd30274;
			6'd25: v = 15'd30853;
			6'd26: v = 15'd31357;
			6'd27: v = 15'd31786;
			6'd28: v = 15'd32138;
			6'd29: v = 15'd32413;
			6'd30: v = 15'd32610;
			6'd31: v = 15'd32729;
			6'd32: v = 15'd32767;
			default: v = 15'd0;
		endcase
		return v;
	endfunction

	// Q8.8 magnitude times Q1.15, back to Q8.8 rounded half up
	function automatic logic [15:0] scale_mag(input logic [15:0] m, input logic [14:0] s);
		logic [30:0] p;
		p = {15'd0, m} * {16'd0, s} + 31'd16384;
		return p[30:15];
	endfunction

	// Attach a sign to a magnitude
	function automatic logic signed [16:0] apply_sign(input logic [15:0] r, input logic neg);
		logic signed [16:0] v;
		v = $signed({1'b0, r});
		return neg ? -v : v;
	endfunction

endpackage

/* rtl/uvsq_sincos.sv */
// Table sine of a fraction of a turn, sign and Q1.15 magnitude, combinational.
// Depends on uvsq_pkg (quarter-wave table).
module uvsq_sincos #(
	parameter int ANGLE_BITS = uvsq_pkg::ANGLE_BITS_DEF
) (
	input  logic [ANGLE_BITS-1:0] angle,
	output logic [14:0]           mag,
	output logic                  neg
);
	localparam int QB = ANGLE_BITS - 2;
	localparam int FB = ANGLE_BITS - 7;
	localparam logic [QB:0] QONE = {1'b1, {QB{1'b0}}};

	logic [QB:0]    ph;
	logic [5:0]     k;
	logic [FB-1:0]  f;
	logic [14:0]    base;
	logic [14:0]    nxt;
	logic [10:0]    d;
	logic [10+FB:0] ip;

	// Fold into the first quarter and interpolate between table entries
	always_comb begin
		ph   = angle[QB] ? (QONE - {1'b0, angle[QB-1:0]}) : {1'b0, angle[QB-1:0]};
		k    = ph[QB:FB];
		f    = ph[FB-1:0];
		base = uvsq_pkg::qsin(k);
		nxt  = uvsq_pkg::qsin(k + 6'd1);
		d    = 11'(nxt - base);
		ip   = {{FB{1'b0}}, d} * {11'd0, f} + (11 + FB)'(1 << (FB - 1));
		mag  = k[5] ? 15'd32767 : base + 15'(ip[10+FB:FB]);
		neg  = angle[ANGLE_BITS-1];
	end
endmodule

/* rtl/uvsq_div.sv */
// Pipelined restoring divider: floor(num * 2^ANGLE_BITS / den), one quotient bit a stage.
// No package dependencies beyond the parameter default.
module uvsq_div #(
	parameter int ANGLE_BITS = uvsq_pkg::ANGLE_BITS_DEF
) (
	input  logic                clk,
	input  logic [8:0]          num,
	input  logic [8:0]          den,
	output logic [ANGLE_BITS:0] quo
);
	localparam int AB = ANGLE_BITS;

	logic [8:0]  rem_s [AB+1];
	logic [8:0]  den_s [AB+1];
	logic [AB:0] quo_s [AB+1];

	// Integer bit first, then one fraction bit per stage
	always_ff @(posedge clk) begin
		den_s[0] <= den;
		if (num >= den) begin
			rem_s[0] <= num - den;
			quo_s[0] <= (AB + 1)'(1);
		end else begin
			rem_s[0] <= num;
			quo_s[0] <= '0;
		end
		for (int i = 1; i <= AB; i++) begin
			den_s[i] <= den_s[i-1];
			if ({rem_s[i-1], 1'b0} >= {1'b0, den_s[i-1]}) begin
				rem_s[i] <= 9'({rem_s[i-1], 1'b0} - {1'b0, den_s[i-1]});
				quo_s[i] <= {quo_s[i-1][AB-1:0], 1'b1};
			end else begin
				rem_s[i] <= {rem_s[i-1][7:0], 1'b0};
				quo_s[i] <= {quo_s[i-1][AB-1:0], 1'b0};
			end
		end
	end

	assign quo = quo_s[AB];
endmodule

/* rtl/uvsq_front.sv */
// Front part: checks indexes, computes ring and sector angles, ring radius and height.
// Depends on uvsq_pkg, uvsq_div and uvsq_sincos.
module uvsq_front #(
	parameter int MAX_GRID   = uvsq_pkg::MAX_GRID_DEF,
	parameter int ANGLE_BITS = uvsq_pkg::ANGLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_accept,
	input  logic [7:0]                    ring_index,
	input  logic [7:0]                    sector_index,
	input  logic [15:0]                   radius,
	input  logic [8:0]                    ring_count,
	input  logic [8:0]                    sector_count,
	output logic                          wr_en,
	output logic [2*ANGLE_BITS+66:0]      wr_data
);
	localparam int AB = ANGLE_BITS;
	localparam logic [AB-1:0] QONE = {2'b01, {(AB - 2){1'b0}}};
	// A cap at or above the largest 9-bit count leaves every count as written
	localparam int GRID_CAP = (MAX_GRID > 511) ? 511 : MAX_GRID;

	logic [8:0]  rings;
	logic [8:0]  sectors;
	logic        bad;
	logic [AB:0] lat_q [2];
	logic [AB:0] lng_q [2];
	logic [AB:0] vld_s;
	logic [AB:0] bad_s;

	// Clamp counts and flag indexes out of range
	always_comb begin
		rings   = (ring_count > 9'(GRID_CAP)) ? 9'(GRID_CAP) : ring_count;
		sectors = (sector_count > 9'(GRID_CAP)) ? 9'(GRID_CAP) : sector_count;
		bad     = ({1'b0, ring_index} >= rings) || ({1'b0, sector_index} >= sectors);
	end

	// Dividers for both rings and both sector edges
	for (genvar k = 0; k < 2; k++) begin : g_div
		uvsq_div #(.ANGLE_BITS(AB)) u_lat (
			.clk(clk), .num({1'b0, ring_index} + 9'(k)), .den(rings), .quo(lat_q[k])
		);
		uvsq_div #(.ANGLE_BITS(AB)) u_lng (
			.clk(clk), .num({1'b0, sector_index} + 9'(k)), .den(sectors), .quo(lng_q[k])
		);
	end

	// Advance valid and bad flags alongside the dividers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[AB-1:0], in_accept};
		end
	end

	always_ff @(posedge clk) begin
		bad_s <= {bad_s[AB-1:0], bad};
	end

	// Latitude sine and cosine for both rings
	logic [AB-1:0] la [2];
	logic [AB-1:0] ca [2];
	logic [14:0]   smag [2];
	logic          sneg [2];
	logic [14:0]   cmag [2];
	logic          cneg [2];

	for (genvar k = 0; k < 2; k++) begin : g_trig
		assign la[k] = lat_q[k][AB:1] - QONE;
		assign ca[k] = la[k] + QONE;
		uvsq_sincos #(.ANGLE_BITS(AB)) u_sin (.angle(la[k]), .mag(smag[k]), .neg(sneg[k]));
		uvsq_sincos #(.ANGLE_BITS(AB)) u_cos (.angle(ca[k]), .mag(cmag[k]), .neg(cneg[k]));
	end

	logic          vld_t1_s;
	logic          bad_t1_s;
	logic [14:0]   smag_t1_s [2];
	logic          sneg_t1_s [2];
	logic [14:0]   cmag_t1_s [2];
	logic          cneg_t1_s [2];
	logic [AB-1:0] lng_t1_s  [2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_t1_s <= 1'b0;
		end else begin
			vld_t1_s <= vld_s[AB];
		end
	end

	// Hold trig results for the radius scaling
	always_ff @(posedge clk) begin
		bad_t1_s <= bad_s[AB];
		for (int k = 0; k < 2; k++) begin
			smag_t1_s[k] <= smag[k];
			sneg_t1_s[k] <= sneg[k];
			cmag_t1_s[k] <= cmag[k];
			cneg_t1_s[k] <= cneg[k];
			lng_t1_s[k]  <= lng_q[k][AB-1:0];
		end
	end

	// Scale by radius and pack the queue entry
	uvsq_pkg::ring_t rg [2];

	always_comb begin
		for (int k = 0; k < 2; k++) begin
			rg[k].zc = uvsq_pkg::apply_sign(uvsq_pkg::scale_mag(radius, smag_t1_s[k]),
				sneg_t1_s[k]);
			// cosine of a latitude carries a sign only together with zero magnitude
			rg[k].rc = cneg_t1_s[k] ? '0 : uvsq_pkg::scale_mag(radius, cmag_t1_s[k]);
		end
		wr_en   = vld_t1_s;
		wr_data = {bad_t1_s, lng_t1_s[1], lng_t1_s[0], rg[1], rg[0]};
	end
endmodule

/* rtl/uvsq_fifo.sv */
// Small queue between the front and the back, register array with read pointer.
// No package dependencies beyond the parameter default.
module uvsq_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = uvsq_pkg::QDEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_en,
	input  logic [W-1:0] wr_data,
	input  logic         rd_en,
	output logic [W-1:0] rd_data,
	output logic         empty
);
	localparam int AW = $clog2(DEPTH);

	logic [W-1:0] mem_q [DEPTH];
	logic [AW:0]  wr_ptr_q;
	logic [AW:0]  rd_ptr_q;

	// Advance pointers on each write and read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + (AW + 1)'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + (AW + 1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q[AW-1:0]] <= wr_data;
		end
	end

	assign rd_data = mem_q[rd_ptr_q[AW-1:0]];
	assign empty   = (wr_ptr_q == rd_ptr_q);
endmodule

/* rtl/uvsq_back.sv */
// Back part: walks the four corners of each queued quad, one vertex per unstalled cycle.
// Depends on uvsq_pkg and uvsq_sincos.
module uvsq_back #(
	parameter int ANGLE_BITS = uvsq_pkg::ANGLE_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [2*ANGLE_BITS+66:0] entry,
	input  logic                     empty,
	output logic                     pop,
	input  logic                     m_ready,
	output logic                     m_valid,
	output logic signed [16:0]       pos_x,
	output logic signed [16:0]       pos_y,
	output logic signed [16:0]       pos_z,
	output logic [1:0]               corner,
	output logic                     bad_index,
	output logic                     last_corner
);
	localparam int AB = ANGLE_BITS;
	localparam logic [AB-1:0] QONE = {2'b01, {(AB - 2){1'b0}}};

	uvsq_pkg::ring_t rg [2];
	logic [AB-1:0]   lng [2];
	logic            e_bad;
	logic [1:0]      cnt_q;
	logic            en;
	logic            upper;
	logic            nxt_lng;
	logic [AB-1:0]   ang;
	logic [AB-1:0]   cang;
	logic [14:0]     smag;
	logic            sneg;
	logic [14:0]     cmag;
	logic            cneg;

	// Unpack entry and pick ring and longitude of the current corner
	always_comb begin
		{e_bad, lng[1], lng[0], rg[1], rg[0]} = entry;
		upper   = (cnt_q == 2'd0) || (cnt_q == 2'd1);
		nxt_lng = (cnt_q == 2'd1) || (cnt_q == 2'd2);
		ang     = nxt_lng ? lng[1] : lng[0];
		cang    = ang + QONE;
		en      = !m_valid || m_ready;
		pop     = en && !empty && (cnt_q == uvsq_pkg::CORNER_LAST);
	end

	uvsq_sincos #(.ANGLE_BITS(AB)) u_sin (.angle(ang), .mag(smag), .neg(sneg));
	uvsq_sincos #(.ANGLE_BITS(AB)) u_cos (.angle(cang), .mag(cmag), .neg(cneg));

	logic               vld_s1;
	logic [14:0]        smag_s1;
	logic               sneg_s1;
	logic [14:0]        cmag_s1;
	logic               cneg_s1;
	logic [15:0]        rc_s1;
	logic signed [16:0] zc_s1;
	logic [1:0]         corner_s1;
	logic               bad_s1;

	// Corner counter and stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			vld_s1  <= 1'b0;
			m_valid <= 1'b0;
		end else if (en) begin
			vld_s1  <= !empty;
			m_valid <= vld_s1;
			if (!empty) begin
				cnt_q <= cnt_q + 2'd1;
			end
		end
	end

	// Trig stage, then scale into the output register
	always_ff @(posedge clk) begin
		if (en) begin
			smag_s1   <= smag;
			sneg_s1   <= sneg;
			cmag_s1   <= cmag;
			cneg_s1   <= cneg;
			rc_s1     <= upper ? rg[1].rc : rg[0].rc;
			zc_s1     <= upper ? rg[1].zc : rg[0].zc;
			corner_s1 <= cnt_q;
			bad_s1    <= e_bad;

			pos_x       <= bad_s1 ? '0 :
				uvsq_pkg::apply_sign(uvsq_pkg::scale_mag(rc_s1, cmag_s1), cneg_s1);
			pos_y       <= bad_s1 ? '0 :
				uvsq_pkg::apply_sign(uvsq_pkg::scale_mag(rc_s1, smag_s1), sneg_s1);
			pos_z       <= bad_s1 ? '0 : zc_s1;
			corner      <= corner_s1;
			bad_index   <= bad_s1;
			last_corner <= (corner_s1 == uvsq_pkg::CORNER_LAST);
		end
	end
endmodule

/* rtl/uv_sphere_quad_vertex_gen_unit.sv */
// UV sphere quad vertex generator, top level.
// Depends on uvsq_pkg, uvsq_front, uvsq_fifo and uvsq_back.
//
// Usage:
// - Write radius (Q8.8), ring_count and sector_count through cfg_we/cfg_index/cfg_data
//   while no request is in flight. Indexes beyond the register list are ignored.
// - Each transfer on s_* carries ring_index and sector_index of one quad. Four transfers
//   follow on m_*: the corners upper/first, upper/next, lower/next, lower/first
//   longitude, with tlast on the fourth. tuser flags an index at or beyond its count;
//   the coordinates are then zero.
// - Throughput: one vertex per cycle while m_tready does not stall the back end, through
//   its shared sine table and multipliers.
// - The path from the input transfer to the first vertex runs through the bit-per-stage
//   angle dividers in the front end, the queue and the back end.
// - A queue of QDEPTH quads decouples the front from the back; s_tready falls when
//   QDEPTH quads are accepted and not yet walked by the back end.
// - When m_tready is low the output holds and the back end stalls; the front keeps
//   going until its credits run out.
// - Reset clears all pipelines and the queue and loads radius 1.0 and counts of 8.
module uv_sphere_quad_vertex_gen_unit #(
	parameter int MAX_GRID   = uvsq_pkg::MAX_GRID_DEF,
	parameter int ANGLE_BITS = uvsq_pkg::ANGLE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // ring_index[7:0], sector_index[15:8]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // pos_x[16:0], pos_y[33:17], pos_z[50:34], corner[52:51]
	output logic        m_tlast,   // last_corner
	output logic        m_tuser    // bad_index
);
	localparam int EW = 2 * ANGLE_BITS + 67;
	localparam int CW = $clog2(uvsq_pkg::QDEPTH + 1);

	logic [15:0] radius_q;
	logic [8:0]  ring_count_q;
	logic [8:0]  sector_count_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q       <= uvsq_pkg::RADIUS_RST;
			ring_count_q   <= uvsq_pkg::COUNT_RST;
			sector_count_q <= uvsq_pkg::COUNT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				uvsq_pkg::REG_RADIUS:       radius_q       <= cfg_data;
				uvsq_pkg::REG_RING_COUNT:   ring_count_q   <= cfg_data[8:0];
				uvsq_pkg::REG_SECTOR_COUNT: sector_count_q <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	logic          in_acc;
	logic          wr_en;
	logic [EW-1:0] wr_data;
	logic [EW-1:0] rd_data;
	logic          empty;
	logic          pop;
	logic [CW-1:0] inflight_q;

	assign in_acc   = s_tvalid && s_tready;
	assign s_tready = (inflight_q < CW'(uvsq_pkg::QDEPTH));

	// Track quads accepted and not yet taken by the back end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (in_acc && !pop) begin
			inflight_q <= inflight_q + CW'(1);
		end else if (!in_acc && pop) begin
			inflight_q <= inflight_q - CW'(1);
		end
	end

	uvsq_front #(.MAX_GRID(MAX_GRID), .ANGLE_BITS(ANGLE_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .in_accept(in_acc),
		.ring_index(s_tdata[7:0]), .sector_index(s_tdata[15:8]),
		.radius(radius_q), .ring_count(ring_count_q), .sector_count(sector_count_q),
		.wr_en(wr_en), .wr_data(wr_data)
	);

	uvsq_fifo #(.W(EW), .DEPTH(uvsq_pkg::QDEPTH)) u_fifo (
		.clk(clk), .arst_n(arst_n), .wr_en(wr_en), .wr_data(wr_data),
		.rd_en(pop), .rd_data(rd_data), .empty(empty)
	);

	logic signed [16:0] pos_x;
	logic signed [16:0] pos_y;
	logic signed [16:0] pos_z;
	logic [1:0]         corner;

	uvsq_back #(.ANGLE_BITS(ANGLE_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .entry(rd_data), .empty(empty), .pop(pop),
		.m_ready(m_tready), .m_valid(m_tvalid),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .corner(corner),
		.bad_index(m_tuser), .last_corner(m_tlast)
	);

	assign m_tdata = {3'b000, corner, pos_z, pos_y, pos_x};

	// Credits never exceed the queue depth
	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= CW'(uvsq_pkg::QDEPTH))
		else $error("in-flight count beyond queue depth");

	// An accepted quad holds a credit
	a_credit_taken: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (inflight_q != '0))
		else $error("accepted quad without credit");

	// The marked vertex is the fourth corner
	a_last_corner: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (corner == uvsq_pkg::CORNER_LAST)))
		else $error("tlast not on fourth corner");

	// A flagged vertex carries zero coordinates
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (pos_x == '0 && pos_y == '0 && pos_z == '0))
		else $error("bad index with nonzero coordinates");
endmodule

/* sim/tb_uv_sphere_quad_vertex_gen_unit.sv */
// Self-checking testbench for the UV sphere quad vertex generator.
// Depends on uvsq_pkg and uv_sphere_quad_vertex_gen_unit; predicts each corner in fixed point.
`timescale 1ns / 100ps

module tb_uv_sphere_quad_vertex_gen_unit;

	typedef struct {
		logic signed [16:0] x;
		logic signed [16:0] y;
		logic signed [16:0] z;
		logic [1:0]         corner;
		logic               bad;
		logic               last;
	} vertex_t;

	typedef enum {ROW_QUAD, ROW_BAD, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t kind;
		int        a;   // ring index, or register index
		int        b;   // sector index, or register data
	} row_t;

	localparam int SIN_TAB [0:32] = '{
		0, 1608, 3212, 4808, 6393, 7962, 9512, 11039,
		12540, 14010, 15447, 16846, 18205, 19520, 20788, 22006,
		23170, 24279, 25330, 26320, 27246, 28106, 28899, 29622,
		30274, 30853, 31357, 31786, 32138, 32413, 32610, 32729,
		32767
	};

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;
	logic        m_tlast;
	logic        m_tuser;

	vertex_t corner_queue[$];
	int      mismatches;
	int      send_idle_pct;
	int      recv_idle_pct;
	bit      hold_tok;

	// shadow of the register file
	int      sh_radius;
	int      sh_rings;
	int      sh_sectors;

	uv_sphere_quad_vertex_gen_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// sine over a quarter turn: table lookup plus linear interpolation
	function automatic int quarter_wave(int p);
		int k, f, d;
		k = p >> 9;
		if (k >= 32) return 32767;
		f = p & 511;
		d = SIN_TAB[k + 1] - SIN_TAB[k];
		return SIN_TAB[k] + ((d * f + 256) >> 9);
	endfunction

	function automatic int sine_of(int a);
		int q, p, m;
		a = a & 16'hFFFF;
		q = (a >> 14) & 3;
		p = a & 16'h3FFF;
		m = q[0] ? quarter_wave(16384 - p) : quarter_wave(p);
		return (q >= 2) ? -m : m;
	endfunction

	function automatic int cosine_of(int a);
		return sine_of(a + 16384);
	endfunction

	// Q8.8 magnitude times Q1.15, rounded half away from zero
	function automatic int mul_q15(int mag, int s);
		longint r;
		r = (longint'(mag) * longint'(s < 0 ? -s : s) + 16384) >>> 15;
		return (s < 0) ? -int'(r) : int'(r);
	endfunction

	function automatic int clamp_grid(int c);
		return (c > 256) ? 256 : c;
	endfunction

	// work out the four corners of a quad from the shadow registers
	task automatic predict_quad(input int ri, input int si);
		int      rings, sectors, la, k, c, m, a;
		int      zc[2];
		int      rc[2];
		int      lng[2];
		bit      bad;
		vertex_t v;
		rings   = clamp_grid(sh_rings);
		sectors = clamp_grid(sh_sectors);
		bad     = (ri >= rings) || (si >= sectors);
		for (k = 0; k < 2; k++) begin
			zc[k] = 0; rc[k] = 0; lng[k] = 0;
			if (!bad) begin
				la     = (((ri + k) << 15) / rings - 16384) & 16'hFFFF;
				zc[k]  = mul_q15(sh_radius, sine_of(la));
				rc[k]  = mul_q15(sh_radius, cosine_of(la));
				lng[k] = (((si + k) << 16) / sectors) & 16'hFFFF;
			end
		end
		for (c = 0; c < 4; c++) begin
			// corners 0,1 on the upper ring; 1,2 at the next longitude
			m = rc[c < 2];
			a = lng[c == 1 || c == 2];
			v.x      = bad ? 17'sd0 : 17'(mul_q15(m, cosine_of(a)));
			v.y      = bad ? 17'sd0 : 17'(mul_q15(m, sine_of(a)));
			v.z      = bad ? 17'sd0 : 17'(zc[c < 2]);
			v.corner = 2'(c);
			v.bad    = bad;
			v.last   = (2'(c) == uvsq_pkg::CORNER_LAST);
			corner_queue = {corner_queue, v};
		end
	endtask

	// typed expectation for a quad with an out-of-range index
	task automatic expect_bad_quad();
		vertex_t v;
		for (int c = 0; c < 4; c++) begin
			v = '{x: 17'sd0, y: 17'sd0, z: 17'sd0, corner: 2'(c), bad: 1'b1,
				last: (2'(c) == uvsq_pkg::CORNER_LAST)};
			corner_queue = {corner_queue, v};
		end
	endtask

	// one register write, then a quiet cycle on the write enable
	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		case (idx)
			uvsq_pkg::REG_RADIUS:       sh_radius  = val;
			uvsq_pkg::REG_RING_COUNT:   sh_rings   = val[8:0];
			uvsq_pkg::REG_SECTOR_COUNT: sh_sectors = val[8:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// offer one quad, hold until the transfer, then record what it should produce
	task automatic send_quad(input int ri, input int si, input bit typed_bad);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {8'(si), 8'(ri)};
		do @(posedge clk); while (!s_tready);
		if (typed_bad) expect_bad_quad();
		else predict_quad(ri, si);
	endtask

	// drain everything outstanding, then let the pipeline settle
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (corner_queue.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// receiver: random stalls, plus a long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		int  hold_left;
		bit  hold_seen;
		if (!arst_n) begin
			m_tready  <= 1'b0;
			hold_left = 0;
			hold_seen = 1'b0;
		end else begin
			if (hold_tok != hold_seen) begin
				hold_seen = hold_tok;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left = hold_left - 1;
				m_tready  <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// compare each output transfer with the oldest expected corner
	always @(posedge clk) begin
		vertex_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (corner_queue.size() == 0) begin
				$error("unexpected vertex transfer: %h", m_tdata);
				mismatches++;
			end else begin
				e = corner_queue.pop_front();
				if (m_tdata[16:0] !== e.x) begin
					$error("pos_x exp %0d got %0d", e.x, $signed(m_tdata[16:0]));
					mismatches++;
				end
				if (m_tdata[33:17] !== e.y) begin
					$error("pos_y exp %0d got %0d", e.y, $signed(m_tdata[33:17]));
					mismatches++;
				end
				if (m_tdata[50:34] !== e.z) begin
					$error("pos_z exp %0d got %0d", e.z, $signed(m_tdata[50:34]));
					mismatches++;
				end
				if (m_tdata[52:51] !== e.corner) begin
					$error("corner exp %0d got %0d", e.corner, m_tdata[52:51]);
					mismatches++;
				end
				if (m_tuser !== e.bad) begin
					$error("bad_index exp %0d got %0d", e.bad, m_tuser);
					mismatches++;
				end
				if (m_tlast !== e.last) begin
					$error("last_corner exp %0d got %0d", e.last, m_tlast);
					mismatches++;
				end
			end
		end
	end

	// watchdog
	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		row_t rows[$];
		int   ph, n, rings, sectors, ri, si;
		rows = '{
			'{ROW_QUAD, 0, 0}, '{ROW_QUAD, 7, 7}, '{ROW_QUAD, 0, 7}, '{ROW_QUAD, 7, 0},
			'{ROW_QUAD, 3, 5}, '{ROW_BAD, 8, 0}, '{ROW_BAD, 0, 8}, '{ROW_BAD, 255, 255},
			'{ROW_BAD, 255, 0},
			'{ROW_CFG, 3, 16'hFFFF}, '{ROW_CFG, uvsq_pkg::REG_RADIUS, 16'hFFFF},
			'{ROW_CFG, uvsq_pkg::REG_RING_COUNT, 1},
			'{ROW_CFG, uvsq_pkg::REG_SECTOR_COUNT, 1},
			'{ROW_QUAD, 0, 0}, '{ROW_BAD, 1, 0}, '{ROW_BAD, 0, 1},
			'{ROW_CFG, uvsq_pkg::REG_RING_COUNT, 0}, '{ROW_BAD, 0, 0},
			'{ROW_CFG, uvsq_pkg::REG_RADIUS, 0},
			'{ROW_CFG, uvsq_pkg::REG_RING_COUNT, 16'hFFFF},
			'{ROW_CFG, uvsq_pkg::REG_SECTOR_COUNT, 300},
			'{ROW_QUAD, 255, 255}, '{ROW_QUAD, 128, 1}
		};
		mismatches    = 0;
		hold_tok      = 1'b0;
		send_idle_pct = 37;
		recv_idle_pct = 60;
		sh_radius     = uvsq_pkg::RADIUS_RST;
		sh_rings      = uvsq_pkg::COUNT_RST;
		sh_sectors    = uvsq_pkg::COUNT_RST;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = uvsq_pkg::REG_RADIUS;
		cfg_data      = 16'd0;
		s_tvalid      = 1'b0;
		s_tdata       = 16'd0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (rows[i]) begin
			case (rows[i].kind)
				ROW_CFG: begin
					wait_idle();
					write_reg(2'(rows[i].a), 16'(rows[i].b));
				end
				ROW_BAD:  send_quad(rows[i].a, rows[i].b, 1'b1);
				default:  send_quad(rows[i].a, rows[i].b, 1'b0);
			endcase
		end

		// random phases: new settings each, idling pattern shifts across them
		for (ph = 0; ph < 8; ph++) begin
			wait_idle();
			send_idle_pct = (ph < 3) ? 37 : (ph < 6) ? 60 : 0;
			recv_idle_pct = (ph < 3) ? 60 : (ph < 6) ? 37 : 0;
			write_reg(uvsq_pkg::REG_RADIUS, (ph == 1) ? 16'hFFFF : 16'($urandom));
			write_reg(uvsq_pkg::REG_RING_COUNT, (ph == 0) ? 16'd256 :
				($urandom_range(3) == 0) ? 16'($urandom_range(511)) :
				16'($urandom_range(256, 1)));
			write_reg(uvsq_pkg::REG_SECTOR_COUNT, (ph == 0) ? 16'd256 :
				($urandom_range(3) == 0) ? 16'($urandom_range(511)) :
				16'($urandom_range(256, 1)));
			if ($urandom_range(1)) write_reg(2'd3, 16'($urandom));
			rings   = clamp_grid(sh_rings);
			sectors = clamp_grid(sh_sectors);
			// long receiver stall so the internal queue fills and backs up the input
			if (ph == 7) hold_tok = ~hold_tok;
			for (n = 0; n < 42; n++) begin
				if (rings > 0 && sectors > 0 && $urandom_range(9) != 0) begin
					ri = $urandom_range(rings - 1);
					si = $urandom_range(sectors - 1);
				end else begin
					ri = $urandom_range(255);
					si = $urandom_range(255);
				end
				send_quad(ri, si, 1'b0);
			end
		end
		wait_idle();

		if (mismatches == 0 && corner_queue.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
